@@ src/mcc_pkg.sv @@
package mcc_pkg;

  localparam int REG_COINS      = 4;
  localparam int COIN_IDX_W     = 2;
  localparam int COIN_W         = 8;
  localparam int AMOUNT_W       = 8;
  localparam int CNT_W          = 8;
  localparam int ENTRY_W        = CNT_W + 1;
  localparam int ENTRY_VB       = CNT_W;
  localparam int NUM_COINS      = 4;
  localparam int MAX_AMOUNT_DEF = 255;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [COIN_W-1:0] COIN_RESET [REG_COINS] = '{
    8'd1, 8'd2, 8'd4, 8'd7
  };

  typedef struct packed {
    logic load_query;
    logic clear_wr;
    logic coin_start;
    logic coin_next;
    logic issue;
    logic rd_result;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_ovf;
    logic j_last;
    logic i_last;
    logic coin_ok;
  } sts_t;

endpackage

@@ src/mcc_dp.sv @@
module mcc_dp #(
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mcc_pkg::COIN_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcc_pkg::COIN_W-1:0]      cfg_data_i,
  input  logic [mcc_pkg::AMOUNT_W-1:0]    amount_i,
  input  logic [mcc_pkg::COIN_IDX_W-1:0]  last_coin_i,
  input  mcc_pkg::cmd_t                   cmd_i,
  output mcc_pkg::sts_t                   sts_o,
  output logic [mcc_pkg::CNT_W-1:0]       min_coins_o,
  output logic                            reachable_o
);
  import mcc_pkg::*;

  localparam int DEPTH = MAX_AMOUNT + 1;
  localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int XW    = (AW > COIN_W) ? AW : COIN_W;
  localparam int UC    = (NUM_COINS < REG_COINS) ? NUM_COINS : REG_COINS;
  localparam logic [COIN_IDX_W-1:0] TOP_MAX = COIN_IDX_W'(UC - 1);

  logic [COIN_W-1:0]     coin_q [REG_COINS];
  logic [ENTRY_W-1:0]    mem [DEPTH];

  logic [AW-1:0]         j_q, amt_q, s1_j_q;
  logic [COIN_IDX_W-1:0] i_q, top_q;
  logic                  ovf_q, s1_v_q, fwd_q;
  logic [ENTRY_W-1:0]    rd_a_q, rd_b_q, fwd_data_q;

  logic [COIN_IDX_W-1:0] top_in;
  logic [COIN_W-1:0]     coin;
  logic [XW-1:0]         coin_x, amt_x, j_x;
  logic [AW-1:0]         prev_addr, addr_a, waddr;
  logic [ENTRY_W-1:0]    prev, cur, upd, wdata;
  logic [CNT_W-1:0]      cand;
  logic                  better, we;

  assign top_in    = (last_coin_i > TOP_MAX) ? TOP_MAX : last_coin_i;
  assign coin      = coin_q[i_q];
  assign coin_x    = XW'(coin);
  assign amt_x     = XW'(amt_q);
  assign j_x       = XW'(j_q);
  assign prev_addr = AW'(j_x - coin_x);
  assign addr_a    = cmd_i.rd_result ? amt_q : prev_addr;

  // newest write bypasses the memory when the step equals one
  assign prev   = fwd_q ? fwd_data_q : rd_a_q;
  assign cur    = rd_b_q;
  assign cand   = (prev[CNT_W-1:0] == CNT_MAX) ? CNT_MAX : prev[CNT_W-1:0] + 1'b1;
  assign better = prev[ENTRY_VB] && (!cur[ENTRY_VB] || (cand < cur[CNT_W-1:0]));
  assign upd    = better ? {1'b1, cand} : cur;

  assign we    = cmd_i.clear_wr || s1_v_q;
  assign waddr = cmd_i.clear_wr ? j_q : s1_j_q;
  assign wdata = cmd_i.clear_wr ? ((j_q == '0) ? {1'b1, {CNT_W{1'b0}}} : '0) : upd;

  assign sts_o.in_ovf  = ({{(32-AMOUNT_W){1'b0}}, amount_i} > 32'(MAX_AMOUNT));
  assign sts_o.j_last  = (j_q == amt_q);
  assign sts_o.i_last  = (i_q == top_q);
  assign sts_o.coin_ok = (coin != '0) && (coin_x <= amt_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < REG_COINS; k++) begin
        coin_q[k] <= COIN_RESET[k];
      end
    end else if (cfg_we_i) begin
      coin_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.issue || cmd_i.rd_result) begin
      rd_a_q <= mem[addr_a];
    end
    if (cmd_i.issue) begin
      rd_b_q <= mem[j_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
      ovf_q  <= 1'b0;
      i_q    <= '0;
    end else begin
      s1_v_q <= cmd_i.issue;
      fwd_q  <= cmd_i.issue && s1_v_q && (prev_addr == s1_j_q);
      if (cmd_i.load_query) begin
        ovf_q <= sts_o.in_ovf;
        i_q   <= '0;
      end else if (cmd_i.coin_next) begin
        i_q <= i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= upd;
    if (cmd_i.issue) begin
      s1_j_q <= j_q;
    end
    if (cmd_i.load_query) begin
      amt_q <= AW'(amount_i);
      top_q <= top_in;
      j_q   <= '0;
    end else if (cmd_i.coin_start) begin
      j_q <= AW'(coin_x);
    end else if (cmd_i.clear_wr || cmd_i.issue) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      reachable_o <= !ovf_q && rd_a_q[ENTRY_VB];
      min_coins_o <= (!ovf_q && rd_a_q[ENTRY_VB]) ? rd_a_q[CNT_W-1:0] : '0;
    end
  end

  a_fwd_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_v_q)
    else $error("bypass active without an update in flight");

  a_s1_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (s1_j_q <= amt_q))
    else $error("table update beyond the requested amount");

endmodule

@@ src/mcc_ctrl.sv @@
module mcc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  mcc_pkg::sts_t sts_i,
  output mcc_pkg::cmd_t cmd_o
);
  import mcc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_PASS  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_RDMEM = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_query = 1'b1;
          state_d = sts_i.in_ovf ? S_FIN : S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.j_last) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.coin_ok) begin
          cmd_o.coin_start = 1'b1;
          state_d = S_PASS;
        end else if (sts_i.i_last) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.coin_next = 1'b1;
        end
      end
      S_PASS: begin
        cmd_o.issue = 1'b1;
        if (sts_i.j_last) begin
          if (sts_i.i_last) begin
            state_d = S_DRAIN;
          end else begin
            cmd_o.coin_next = 1'b1;
            state_d = S_LOAD;
          end
        end
      end
      S_DRAIN: begin
        state_d = S_RDMEM;
      end
      S_RDMEM: begin
        cmd_o.rd_result = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.issue, cmd_o.clear_wr, cmd_o.rd_result, cmd_o.out_load}))
    else $error("conflicting datapath commands");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transaction");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CLEAR || state_q == S_FIN))
    else $error("bad state after input transaction");

endmodule

@@ src/min_coin_change_unit.sv @@
// Minimum coin change: returns the fewest coins from types 0..last_coin that
// sum to amount exactly, each type usable any number of times, and a
// reachable flag (count 0 when unreachable; amount 0 is reachable with 0
// coins; a coin value of 0 is skipped). Denominations come from four 8-bit
// registers written through cfg_we_i/cfg_idx_i/cfg_data_i; write them only
// while idle, which the block itself does not enforce. One query at a time:
// the work of a query is set by the single-write table memory that is
// cleared once and then swept one entry per cycle for each allowed coin,
// from its value up to the amount. A finished result sits in the output
// register so the next query can start.
module min_coin_change_unit #(
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mcc_pkg::COIN_IDX_W-1:0] cfg_idx_i,
  input  logic [mcc_pkg::COIN_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mcc_pkg::AMOUNT_W-1:0]   amount_i,
  input  logic [mcc_pkg::COIN_IDX_W-1:0] last_coin_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mcc_pkg::CNT_W-1:0]      min_coins_o,
  output logic                           reachable_o
);
  import mcc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcc_dp #(
    .MAX_AMOUNT (MAX_AMOUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .amount_i    (amount_i),
    .last_coin_i (last_coin_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .min_coins_o (min_coins_o),
    .reachable_o (reachable_o)
  );

endmodule
